@@ design/lfr_pkg.sv @@
// Shared types and codes for the LFU frame replacer.
`default_nettype none
package lfr_pkg;

   // Command codes carried by an input item
   localparam logic CMD_FAULT  = 1'b0;
   localparam logic CMD_ACCESS = 1'b1;

   // Sequencer states of the top level
   typedef enum logic [2:0] {
      ST_IDLE,
      ST_SCAN,
      ST_FETCH,
      ST_FAULT_DONE,
      ST_ACC_READ,
      ST_ACC_WRITE
   } lfr_state_type;

   // Control of the shared pick unit
   typedef struct packed {
      logic clear;
      logic sample;
   } lfr_pick_ctl_type;

endpackage
`default_nettype wire

@@ design/lfr_frame_table.sv @@
// Frame table: valid flops plus owner, page, dirty and use-count memories.
`default_nettype none
module lfr_frame_table #(
   parameter int FRAME_BITS = 4,
   parameter int PAGE_BITS  = 20,
   parameter int PROC_BITS  = 8,
   parameter int COUNT_BITS = 16
) (
   input  wire logic                  clock,
   input  wire logic                  reset,
   input  wire logic [FRAME_BITS-1:0] rd_addr,
   output logic                       rd_valid_ff,
   output logic      [PROC_BITS-1:0]  rd_owner_ff,
   output logic      [PAGE_BITS-1:0]  rd_page_ff,
   output logic                       rd_dirty_ff,
   output logic      [COUNT_BITS-1:0] rd_uses_ff,
   input  wire logic                  wr_en,
   input  wire logic [FRAME_BITS-1:0] wr_addr,
   input  wire logic [PROC_BITS-1:0]  wr_owner,
   input  wire logic [PAGE_BITS-1:0]  wr_page,
   input  wire logic                  wr_dirty,
   input  wire logic [COUNT_BITS-1:0] wr_uses
);

   localparam int N = 1 << FRAME_BITS;

   logic [N-1:0]          valid_ff;
   logic [PROC_BITS-1:0]  owner_mem [N];
   logic [PAGE_BITS-1:0]  page_mem  [N];
   logic                  dirty_mem [N];
   logic [COUNT_BITS-1:0] uses_mem  [N];

   // Clear valid bits at reset; any write makes the frame valid
   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= '0;
      end else if (wr_en) begin
         valid_ff[wr_addr] <= 1'b1;
      end
   end

   // Write entry payload
   always_ff @(posedge clock) begin
      if (wr_en) begin
         owner_mem[wr_addr] <= wr_owner;
         page_mem[wr_addr]  <= wr_page;
         dirty_mem[wr_addr] <= wr_dirty;
         uses_mem[wr_addr]  <= wr_uses;
      end
   end

   // Registered read of one entry
   always_ff @(posedge clock) begin
      rd_valid_ff <= valid_ff[rd_addr];
      rd_owner_ff <= owner_mem[rd_addr];
      rd_page_ff  <= page_mem[rd_addr];
      rd_dirty_ff <= dirty_mem[rd_addr];
      rd_uses_ff  <= uses_mem[rd_addr];
   end

endmodule
`default_nettype wire

@@ design/lfr_pick_unit.sv @@
// Shared compare unit: tracks the first free frame or the least-used one.
`default_nettype none
module lfr_pick_unit #(
   parameter int FRAME_BITS = 4,
   parameter int COUNT_BITS = 16
) (
   input  wire logic                     clock,
   input  wire logic                     reset,
   input  wire lfr_pkg::lfr_pick_ctl_type ctl,
   input  wire logic [FRAME_BITS-1:0]    cand_index,
   input  wire logic                     cand_valid,
   input  wire logic [COUNT_BITS-1:0]    cand_uses,
   output logic      [FRAME_BITS-1:0]    pick_ff
);

   logic                  have_free_ff, have_free_in;
   logic                  have_best_ff, have_best_in;
   logic [FRAME_BITS-1:0] pick_in;
   logic [COUNT_BITS-1:0] best_uses_ff, best_uses_in;

   // Compare one candidate per cycle while sample is set; a free frame wins and then holds
   always_comb begin
      have_free_in = have_free_ff;
      have_best_in = have_best_ff;
      pick_in      = pick_ff;
      best_uses_in = best_uses_ff;
      if (ctl.clear) begin
         have_free_in = 1'b0;
         have_best_in = 1'b0;
      end else if (ctl.sample && !have_free_ff) begin
         if (!cand_valid) begin
            have_free_in = 1'b1;
            pick_in      = cand_index;
         end else if (!have_best_ff || (cand_uses < best_uses_ff)) begin
            have_best_in = 1'b1;
            pick_in      = cand_index;
            best_uses_in = cand_uses;
         end
      end
   end

   // Hold search status
   always_ff @(posedge clock) begin
      if (reset) begin
         have_free_ff <= 1'b0;
         have_best_ff <= 1'b0;
      end else begin
         have_free_ff <= have_free_in;
         have_best_ff <= have_best_in;
      end
   end

   // Hold best candidate
   always_ff @(posedge clock) begin
      pick_ff      <= pick_in;
      best_uses_ff <= best_uses_in;
   end

endmodule
`default_nettype wire

@@ design/lfu_frame_replacer_core.sv @@
// Top level of the LFU frame replacer: sequencer, request capture and result register.
//
//   channel | direction | handshake           | payload
//   req     | in        | req_valid/req_stall | cmd, process_id, page, frame_in, is_write
//   rsp     | out       | rsp_valid/rsp_stall | frame, evicted, old_process, old_page,
//           |           |                     | writeback, tlb_invalidate
//
// A fault reads the table once per frame to feed the shared pick unit, then reads
// the chosen entry and writes it.
// An access reads, then updates the touched frame if it is mapped; it gives no result.
// Reset clears the valid flops at once; no clearing pass is needed.
// A held result waits in the output register; a later fault waits at its final
// step until that register is free. req_stall is high while an item is in work.
`default_nettype none
module lfu_frame_replacer_core #(
   parameter int FRAME_BITS = 4,
   parameter int PAGE_BITS  = 20,
   parameter int PROC_BITS  = 8,
   parameter int COUNT_BITS = 16
) (
   input  wire logic                  clock,
   input  wire logic                  reset,
   input  wire logic                  req_valid,
   output logic                       req_stall,
   input  wire logic                  req_cmd,
   input  wire logic [PROC_BITS-1:0]  req_process_id,
   input  wire logic [PAGE_BITS-1:0]  req_page,
   input  wire logic [FRAME_BITS-1:0] req_frame_in,
   input  wire logic                  req_is_write,
   output logic                       rsp_valid,
   input  wire logic                  rsp_stall,
   output logic      [FRAME_BITS-1:0] rsp_frame,
   output logic                       rsp_evicted,
   output logic      [PROC_BITS-1:0]  rsp_old_process,
   output logic      [PAGE_BITS-1:0]  rsp_old_page,
   output logic                       rsp_writeback,
   output logic                       rsp_tlb_invalidate
);

   localparam int N = 1 << FRAME_BITS;
   localparam logic [FRAME_BITS:0]   SCAN_END  = (FRAME_BITS+1)'(N);
   localparam logic [COUNT_BITS-1:0] COUNT_MAX = '1;

   lfr_pkg::lfr_state_type state_ff, state_in;

   logic [FRAME_BITS:0]   scan_ff, scan_in;
   logic                  sample_ff, sample_in;
   logic [FRAME_BITS-1:0] cand_ff, cand_in;
   logic [PROC_BITS-1:0]  proc_ff;
   logic [PAGE_BITS-1:0]  page_ff;
   logic [FRAME_BITS-1:0] fin_ff;
   logic                  write_ff;

   logic                  rsp_valid_ff, rsp_valid_in;
   logic [FRAME_BITS-1:0] rsp_frame_ff;
   logic                  rsp_evicted_ff;
   logic [PROC_BITS-1:0]  rsp_old_process_ff;
   logic [PAGE_BITS-1:0]  rsp_old_page_ff;
   logic                  rsp_writeback_ff;
   logic                  rsp_tlb_ff;
   logic                  rsp_load;

   logic                  req_take;
   logic                  rsp_free;

   logic [FRAME_BITS-1:0] rd_addr;
   logic                  rd_valid;
   logic [PROC_BITS-1:0]  rd_owner;
   logic [PAGE_BITS-1:0]  rd_page;
   logic                  rd_dirty;
   logic [COUNT_BITS-1:0] rd_uses;

   logic                  wr_en;
   logic [FRAME_BITS-1:0] wr_addr;
   logic [PROC_BITS-1:0]  wr_owner;
   logic [PAGE_BITS-1:0]  wr_page;
   logic                  wr_dirty;
   logic [COUNT_BITS-1:0] wr_uses;

   lfr_pkg::lfr_pick_ctl_type pick_ctl;
   logic [FRAME_BITS-1:0]     pick;

   assign req_stall = (state_ff != lfr_pkg::ST_IDLE);
   assign req_take  = req_valid && !req_stall;
   assign rsp_free  = !rsp_valid_ff || !rsp_stall;

   lfr_frame_table #(
      .FRAME_BITS (FRAME_BITS),
      .PAGE_BITS  (PAGE_BITS),
      .PROC_BITS  (PROC_BITS),
      .COUNT_BITS (COUNT_BITS)
   ) u_table (
      .clock       (clock),
      .reset       (reset),
      .rd_addr     (rd_addr),
      .rd_valid_ff (rd_valid),
      .rd_owner_ff (rd_owner),
      .rd_page_ff  (rd_page),
      .rd_dirty_ff (rd_dirty),
      .rd_uses_ff  (rd_uses),
      .wr_en       (wr_en),
      .wr_addr     (wr_addr),
      .wr_owner    (wr_owner),
      .wr_page     (wr_page),
      .wr_dirty    (wr_dirty),
      .wr_uses     (wr_uses)
   );

   lfr_pick_unit #(
      .FRAME_BITS (FRAME_BITS),
      .COUNT_BITS (COUNT_BITS)
   ) u_pick (
      .clock      (clock),
      .reset      (reset),
      .ctl        (pick_ctl),
      .cand_index (cand_ff),
      .cand_valid (rd_valid),
      .cand_uses  (rd_uses),
      .pick_ff    (pick)
   );

   // Sequence faults and accesses
   always_comb begin
      state_in        = state_ff;
      scan_in         = scan_ff;
      sample_in       = 1'b0;
      cand_in         = cand_ff;
      rd_addr         = scan_ff[FRAME_BITS-1:0];
      pick_ctl.clear  = 1'b0;
      pick_ctl.sample = sample_ff;
      wr_en           = 1'b0;
      wr_addr         = pick;
      wr_owner        = proc_ff;
      wr_page         = page_ff;
      wr_dirty        = write_ff;
      wr_uses         = '0;
      rsp_load        = 1'b0;
      case (state_ff)
         lfr_pkg::ST_IDLE: begin
            scan_in = '0;
            if (req_take) begin
               if (req_cmd == lfr_pkg::CMD_ACCESS) begin
                  state_in = lfr_pkg::ST_ACC_READ;
               end else begin
                  pick_ctl.clear = 1'b1;
                  state_in       = lfr_pkg::ST_SCAN;
               end
            end
         end
         lfr_pkg::ST_SCAN: begin
            // Issue one read per frame; the pick unit sees it in the next cycle
            if (scan_ff != SCAN_END) begin
               sample_in = 1'b1;
               cand_in   = scan_ff[FRAME_BITS-1:0];
               scan_in   = scan_ff + 1'b1;
            end else begin
               state_in = lfr_pkg::ST_FETCH;
            end
         end
         lfr_pkg::ST_FETCH: begin
            rd_addr  = pick;
            state_in = lfr_pkg::ST_FAULT_DONE;
         end
         lfr_pkg::ST_FAULT_DONE: begin
            // Hold the chosen entry until the result register is free
            rd_addr = pick;
            if (rsp_free) begin
               wr_en    = 1'b1;
               rsp_load = 1'b1;
               state_in = lfr_pkg::ST_IDLE;
            end
         end
         lfr_pkg::ST_ACC_READ: begin
            rd_addr  = fin_ff;
            state_in = lfr_pkg::ST_ACC_WRITE;
         end
         lfr_pkg::ST_ACC_WRITE: begin
            // Bump the use count of a mapped frame, saturating
            rd_addr  = fin_ff;
            wr_en    = rd_valid;
            wr_addr  = fin_ff;
            wr_owner = rd_owner;
            wr_page  = rd_page;
            wr_dirty = rd_dirty || write_ff;
            wr_uses  = (rd_uses == COUNT_MAX) ? rd_uses : rd_uses + 1'b1;
            state_in = lfr_pkg::ST_IDLE;
         end
         default: begin
            state_in = lfr_pkg::ST_IDLE;
         end
      endcase
   end

   // Advance control state
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff  <= lfr_pkg::ST_IDLE;
         scan_ff   <= '0;
         sample_ff <= 1'b0;
      end else begin
         state_ff  <= state_in;
         scan_ff   <= scan_in;
         sample_ff <= sample_in;
      end
   end

   // Capture the item and the scan candidate
   always_ff @(posedge clock) begin
      cand_ff <= cand_in;
      if (req_take) begin
         proc_ff  <= req_process_id;
         page_ff  <= req_page;
         fin_ff   <= req_frame_in;
         write_ff <= req_is_write;
      end
   end

   // Result valid: set on load, drop when taken
   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      if (rsp_load) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_valid_ff && !rsp_stall) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // Load result payload from the chosen entry
   always_ff @(posedge clock) begin
      if (rsp_load) begin
         rsp_frame_ff       <= pick;
         rsp_evicted_ff     <= rd_valid;
         rsp_old_process_ff <= rd_valid ? rd_owner : '0;
         rsp_old_page_ff    <= rd_valid ? rd_page : '0;
         rsp_writeback_ff   <= rd_valid && rd_dirty;
         rsp_tlb_ff         <= rd_valid && (rd_owner == proc_ff);
      end
   end

   assign rsp_valid          = rsp_valid_ff;
   assign rsp_frame          = rsp_frame_ff;
   assign rsp_evicted        = rsp_evicted_ff;
   assign rsp_old_process    = rsp_old_process_ff;
   assign rsp_old_page       = rsp_old_page_ff;
   assign rsp_writeback      = rsp_writeback_ff;
   assign rsp_tlb_invalidate = rsp_tlb_ff;

endmodule
`default_nettype wire
